// File: rtl/mpam_pkg.sv
// shared types and constants for the multi-pattern automaton matcher
package mpam_pkg;

    // automaton geometry
    localparam int NODE_COUNT    = 1024;
    localparam int NODE_W        = 10;
    localparam int ALPHABET_SIZE = 26;
    localparam int SYM_W         = 5;
    localparam int ID_W          = 10;
    localparam int CHILD_DEPTH   = NODE_COUNT * ALPHABET_SIZE;
    localparam int CHILD_AW      = $clog2(CHILD_DEPTH);
    localparam int MAX_REPORTS   = 64;
    localparam int CNT_W         = $clog2(MAX_REPORTS + 1);
    localparam int STEP_W        = $clog2(NODE_COUNT + 1);

    // item commands
    typedef enum logic [1:0] {
        CMD_CHILD   = 2'd0,
        CMD_NODE    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_SYMBOL  = 2'd3
    } cmd_t;

    // input transfer payload
    typedef struct packed {
        cmd_t              cmd;
        logic [NODE_W-1:0] node;
        logic [SYM_W-1:0]  symbol;
        logic [NODE_W-1:0] target;
        logic              has_target;
        logic [ID_W-1:0]   terminal_id;
        logic              has_terminal;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [ID_W-1:0] match_id;
        logic            match_valid;
        logic            overflow;
        logic            last;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic step;
        logic fail_hit;
        logic fail_miss;
        logic suf_take;
        logic suf_ovf;
        logic emit_mid;
        logic emit_final;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sym_ok;
        logic child_valid;
        logic cur_is_root;
        logic steps_last;
        logic steps_done;
        logic term_valid;
        logic room;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/mpam_ctrl.sv
// controller state machine sequencing loads, fail walk and suffix walk
module mpam_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mpam_pkg::cmd_t       s_cmd,
    input  mpam_pkg::dp_status_t status,
    output mpam_pkg::dp_cmd_t    cmd
);
    import mpam_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ACK      = 7'b0000010,
        ST_FAIL_RD  = 7'b0000100,
        ST_FAIL_CHK = 7'b0001000,
        ST_SUF_RD   = 7'b0010000,
        ST_SUF_CHK  = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_cmd == CMD_SYMBOL) ? ST_FAIL_RD : ST_ACK;
                end
            end
            ST_ACK: begin
                if (status.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FAIL_RD: begin
                state_next = ST_FAIL_CHK;
            end
            ST_FAIL_CHK: begin
                if (!status.sym_ok) begin
                    cmd.fail_miss = 1'b1;
                    state_next    = ST_DONE;
                end else if (status.child_valid) begin
                    cmd.fail_hit = 1'b1;
                    state_next   = ST_SUF_RD;
                end else if (status.cur_is_root || status.steps_last) begin
                    cmd.fail_miss = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_FAIL_RD;
                end
            end
            ST_SUF_RD: begin
                if (status.cur_is_root || status.steps_done) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SUF_CHK;
                end
            end
            ST_SUF_CHK: begin
                if (status.term_valid && status.room) begin
                    // previous report goes out once the output register frees up
                    if (!status.pend_valid || status.out_free) begin
                        cmd.emit_mid = status.pend_valid;
                        cmd.suf_take = 1'b1;
                        cmd.step     = 1'b1;
                        state_next   = ST_SUF_RD;
                    end
                end else begin
                    cmd.suf_ovf = status.term_valid;
                    cmd.step    = 1'b1;
                    state_next  = ST_SUF_RD;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_mid || cmd.emit_final) |-> status.out_free)
        else $error("result emitted while output register is full");
    a_emit_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_mid && cmd.emit_final))
        else $error("mid and final result emitted together");
    a_symbol_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_cmd == CMD_SYMBOL) |=> state_reg == ST_FAIL_RD)
        else $error("symbol transfer did not start the fail walk");
`endif

endmodule

// File: rtl/mpam_dp.sv
// datapath: automaton table memories, walk registers and result register
module mpam_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mpam_pkg::in_item_t   s_item,
    input  mpam_pkg::dp_cmd_t    cmd,
    output mpam_pkg::dp_status_t status,
    output mpam_pkg::out_item_t  m_item,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import mpam_pkg::*;

    // table memories
    logic [NODE_W:0]   child_mem [CHILD_DEPTH];
    logic [NODE_W-1:0] fail_mem  [NODE_COUNT];
    logic [ID_W:0]     term_mem  [NODE_COUNT];

    logic [NODE_W:0]   child_rd_reg;
    logic [NODE_W-1:0] fail_rd_reg;
    logic [ID_W:0]     term_rd_reg;

    // walk and report registers
    logic [NODE_W-1:0] scan_node_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [STEP_W-1:0] steps_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic              pend_valid_reg;
    logic              ovf_reg;
    out_item_t         out_reg, out_next;
    logic              m_valid_reg;

    logic [CHILD_AW-1:0] child_wr_addr;
    logic [CHILD_AW-1:0] child_rd_addr;
    logic                wr_child;
    logic                wr_node;

    // table addressing
    assign child_wr_addr = CHILD_AW'(s_item.node) * CHILD_AW'(ALPHABET_SIZE)
                         + CHILD_AW'(s_item.symbol);
    assign child_rd_addr = CHILD_AW'(cur_reg) * CHILD_AW'(ALPHABET_SIZE)
                         + CHILD_AW'(sym_reg);
    assign wr_child = cmd.accept && (s_item.cmd == CMD_CHILD)
                    && (s_item.symbol < SYM_W'(ALPHABET_SIZE));
    assign wr_node  = cmd.accept && (s_item.cmd == CMD_NODE);

    // child link memory
    always_ff @(posedge aclk) begin
        if (wr_child) begin
            child_mem[child_wr_addr] <= s_item.has_target ? {1'b1, s_item.target} : '0;
        end
        child_rd_reg <= child_mem[child_rd_addr];
    end

    // fail link memory
    always_ff @(posedge aclk) begin
        if (wr_node) begin
            fail_mem[s_item.node] <= s_item.target;
        end
        fail_rd_reg <= fail_mem[cur_reg];
    end

    // terminal id memory
    always_ff @(posedge aclk) begin
        if (wr_node) begin
            term_mem[s_item.node] <= s_item.has_terminal ? {1'b1, s_item.terminal_id} : '0;
        end
        term_rd_reg <= term_mem[cur_reg];
    end

    // scan position, persists across symbols
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_node_reg <= '0;
        end else if (cmd.accept && s_item.cmd == CMD_RESTART) begin
            scan_node_reg <= '0;
        end else if (cmd.fail_hit) begin
            scan_node_reg <= child_rd_reg[NODE_W-1:0];
        end else if (cmd.fail_miss) begin
            scan_node_reg <= '0;
        end
    end

    // walk pointer and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (cmd.accept) begin
            cur_reg   <= scan_node_reg;
            sym_reg   <= s_item.symbol;
            steps_reg <= '0;
        end else if (cmd.fail_hit) begin
            cur_reg   <= child_rd_reg[NODE_W-1:0];
            steps_reg <= '0;
        end else if (cmd.step) begin
            cur_reg   <= fail_rd_reg;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // pending report and overflow tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else if (cmd.accept) begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cmd.suf_take) begin
                pend_valid_reg <= 1'b1;
                pend_id_reg    <= term_rd_reg[ID_W-1:0];
                count_reg      <= count_reg + 1'b1;
            end
            if (cmd.suf_ovf) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // result register contents
    always_comb begin
        out_next = '0;
        if (cmd.emit_mid) begin
            out_next.match_id    = pend_id_reg;
            out_next.match_valid = 1'b1;
        end else if (pend_valid_reg) begin
            out_next.match_id    = pend_id_reg;
            out_next.match_valid = 1'b1;
            out_next.overflow    = ovf_reg;
            out_next.last        = 1'b1;
        end else begin
            out_next.last = 1'b1;
        end
    end

    // result register, holds until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_mid || cmd.emit_final) begin
            m_valid_reg <= 1'b1;
            out_reg     <= out_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // status to controller
    assign status.sym_ok      = sym_reg < SYM_W'(ALPHABET_SIZE);
    assign status.child_valid = child_rd_reg[NODE_W];
    assign status.cur_is_root = (cur_reg == '0);
    assign status.steps_last  = (steps_reg == STEP_W'(NODE_COUNT - 1));
    assign status.steps_done  = (steps_reg == STEP_W'(NODE_COUNT));
    assign status.term_valid  = term_rd_reg[ID_W];
    assign status.room        = (count_reg < CNT_W'(MAX_REPORTS));
    assign status.pend_valid  = pend_valid_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

`ifndef SYNTHESIS
    a_steps_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= STEP_W'(NODE_COUNT))
        else $error("walk step counter ran past node count");
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REPORTS))
        else $error("report count ran past limit");
    a_pend_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (count_reg != '0))
        else $error("pending report without a counted report");
`endif

endmodule

// File: rtl/multi_pattern_automaton_matcher_unit.sv
// top level: multi-pattern automaton matcher, controller plus datapath
// load or restart: the ack is registered from the ack state once the output register is free
// symbol: the fail walk reads and checks one node per step, then on a hit the suffix walk does the same,
// then the last result is registered once the output register is free; one table read per step
// flow: one item in flight, the next is accepted once the controller is back in idle after its last result
// reset: aresetn synchronous active low; scan position returns to root, tables keep contents
module multi_pattern_automaton_matcher_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mpam_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output mpam_pkg::out_item_t m_item
);
    import mpam_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    mpam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_item.cmd),
        .status  (status),
        .cmd     (cmd)
    );

    // tables and result register
    mpam_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

// File: dv/mpam_match_checker.sv
// checker for the automaton matcher: watches both channels, predicts and compares results
`timescale 1ns / 100ps

module mpam_match_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mpam_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mpam_pkg::out_item_t m_item,
    output int                  mismatches,
    output int                  backlog
);
    import mpam_pkg::*;

    // private copy of the automaton tables and scan position
    logic [NODE_W:0]   child_tab [CHILD_DEPTH];
    logic [NODE_W-1:0] fail_tab  [NODE_COUNT];
    logic [ID_W:0]     term_tab  [NODE_COUNT];
    logic [NODE_W-1:0] cursor;

    // results still owed by the block, oldest first
    out_item_t owed_reports [$];

    initial begin
        mismatches = 0;
        backlog    = 0;
        cursor     = '0;
    end

    // append one result at the tail of the owed list
    task automatic owe_result(input out_item_t r);
        owed_reports.insert(owed_reports.size(), r);
    endtask

    // apply one input transfer to the tables and queue the results it causes
    task automatic automaton_step(input in_item_t it);
        logic [NODE_W-1:0] walk;
        logic [NODE_W:0]   link;
        logic [ID_W:0]     entry;
        out_item_t         lone;
        out_item_t         held;
        bit                found;
        bit                held_ok;
        bit                dropped;
        int                n;
        lone      = '0;
        lone.last = 1'b1;
        held      = '0;
        found     = 1'b0;
        held_ok   = 1'b0;
        dropped   = 1'b0;
        n         = 0;
        if (it.cmd != CMD_SYMBOL) begin
            // table loads and restart answer with a bare ack
            case (it.cmd)
                CMD_CHILD: begin
                    if (int'(it.symbol) < ALPHABET_SIZE)
                        child_tab[int'(it.node) * ALPHABET_SIZE + int'(it.symbol)] =
                            it.has_target ? {1'b1, it.target} : '0;
                end
                CMD_NODE: begin
                    fail_tab[it.node] = it.target;
                    term_tab[it.node] = it.has_terminal ? {1'b1, it.terminal_id} : '0;
                end
                default: cursor = '0;
            endcase
            owe_result(lone);
        end else begin
            // fail-link walk until some node has a child for the letter
            walk = cursor;
            if (int'(it.symbol) < ALPHABET_SIZE) begin
                for (int steps = 0; steps < NODE_COUNT; steps++) begin
                    link = child_tab[int'(walk) * ALPHABET_SIZE + int'(it.symbol)];
                    if (link[NODE_W]) begin
                        found = 1'b1;
                        walk  = link[NODE_W-1:0];
                        break;
                    end
                    if (walk == '0)
                        break;
                    walk = fail_tab[walk];
                end
            end
            if (!found) begin
                cursor = '0;
                owe_result(lone);
            end else begin
                cursor = walk;
                // suffix chain toward the root, one report per terminal up to MAX_REPORTS
                for (int steps = 0; steps < NODE_COUNT && walk != '0; steps++) begin
                    entry = term_tab[walk];
                    if (entry[ID_W]) begin
                        if (n < MAX_REPORTS) begin
                            if (held_ok)
                                owe_result(held);
                            held             = '0;
                            held.match_id    = entry[ID_W-1:0];
                            held.match_valid = 1'b1;
                            held_ok          = 1'b1;
                            n++;
                        end else begin
                            dropped = 1'b1;
                        end
                    end
                    walk = fail_tab[walk];
                end
                if (!held_ok) begin
                    owe_result(lone);
                end else begin
                    held.overflow = dropped;
                    held.last     = 1'b1;
                    owe_result(held);
                end
            end
        end
    endtask

    // compare result transfers first, then account for a new input transfer
    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            cursor = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, none owed: id=%0d valid=%b ovf=%b last=%b",
                             $time, m_item.match_id, m_item.match_valid,
                             m_item.overflow, m_item.last);
                end else begin
                    want = owed_reports.pop_front();
                    if (m_item.match_id !== want.match_id ||
                        m_item.match_valid !== want.match_valid ||
                        m_item.overflow !== want.overflow ||
                        m_item.last !== want.last) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected id=%0d valid=%b ovf=%b last=%b",
                                 $time, want.match_id, want.match_valid,
                                 want.overflow, want.last);
                        $display("%0t:                  actual id=%0d valid=%b ovf=%b last=%b",
                                 $time, m_item.match_id, m_item.match_valid,
                                 m_item.overflow, m_item.last);
                    end
                end
            end
            if (s_valid && s_ready)
                automaton_step(s_item);
        end
        backlog = owed_reports.size();
    end

endmodule

// File: dv/multi_pattern_automaton_matcher_unit_tb.sv
// testbench top for the automaton matcher: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module multi_pattern_automaton_matcher_unit_tb;
    import mpam_pkg::*;

    localparam int          USED_NODES     = 6;
    localparam int          HOT_LETTERS    = 4;
    localparam int          LOADED_LETTERS = HOT_LETTERS + 2;
    localparam int          PHASES         = 4;
    localparam int          PHASE_ITEMS    = 32;
    localparam int          LONG_HOLD      = 400;
    localparam int          SETTLE         = 40;
    localparam int unsigned CYCLE_LIMIT    = 10_000_000;

    localparam logic [SYM_W-1:0] LETTER_A   = 5'd0;
    localparam logic [SYM_W-1:0] LETTER_B   = 5'd1;
    localparam logic [SYM_W-1:0] LETTER_C   = 5'd2;
    localparam logic [SYM_W-1:0] LETTER_Q   = 5'd16;
    localparam logic [SYM_W-1:0] LETTER_Z   = 5'd25;
    localparam logic [SYM_W-1:0] BEYOND_LO  = 5'd26;
    localparam logic [SYM_W-1:0] BEYOND_MID = 5'd30;
    localparam logic [SYM_W-1:0] BEYOND_HI  = 5'd31;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int          mismatches;
    int          backlog;
    int unsigned cycles = 0;
    bit          steady    = 1'b0;
    bit          hold_ask  = 1'b0;
    bit          hold_done = 1'b0;

    always #6 aclk = ~aclk;

    multi_pattern_automaton_matcher_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    mpam_match_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // nodes the scan may ever reach: 0..4 plus the top index
    function automatic logic [NODE_W-1:0] used_node(int i);
        return (i == USED_NODES - 1) ? NODE_W'(NODE_COUNT - 1) : NODE_W'(i);
    endfunction

    // fail links past the root only point to earlier nodes, so chains always reach the root
    function automatic logic [NODE_W-1:0] acyclic_fail(int i);
        if (i == 0)
            return NODE_W'($urandom_range(0, NODE_COUNT - 1));
        return used_node($urandom_range(0, i - 1));
    endfunction

    // letters the text uses: the hot ones plus q and z
    function automatic logic [SYM_W-1:0] loaded_letter(int l);
        if (l < HOT_LETTERS) return SYM_W'(l);
        if (l == HOT_LETTERS) return LETTER_Q;
        return LETTER_Z;
    endfunction

    function automatic logic [SYM_W-1:0] pick_letter();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return SYM_W'($urandom_range(0, HOT_LETTERS - 1));
        if (r < 92) return loaded_letter($urandom_range(0, LOADED_LETTERS - 1));
        return SYM_W'($urandom_range(ALPHABET_SIZE, 31));
    endfunction

    // unused fields carry random bits
    function automatic in_item_t noisy_item(cmd_t c);
        logic [63:0] noise;
        in_item_t    it;
        noise  = {$urandom(), $urandom()};
        it     = noise[$bits(in_item_t)-1:0];
        it.cmd = c;
        return it;
    endfunction

    // one input transfer, then an optional gap with valid low
    task automatic offer(input in_item_t it);
        int gap;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic load_child(input logic [NODE_W-1:0] nd, input logic [SYM_W-1:0] sym,
                              input bit present, input logic [NODE_W-1:0] dest);
        in_item_t it;
        it            = noisy_item(CMD_CHILD);
        it.node       = nd;
        it.symbol     = sym;
        it.has_target = present;
        it.target     = dest;
        offer(it);
    endtask

    task automatic load_node(input logic [NODE_W-1:0] nd, input logic [NODE_W-1:0] fail,
                             input bit is_term, input logic [ID_W-1:0] id);
        in_item_t it;
        it              = noisy_item(CMD_NODE);
        it.node         = nd;
        it.target       = fail;
        it.has_terminal = is_term;
        it.terminal_id  = id;
        offer(it);
    endtask

    task automatic scan_letter(input logic [SYM_W-1:0] sym);
        in_item_t it;
        it        = noisy_item(CMD_SYMBOL);
        it.symbol = sym;
        offer(it);
    endtask

    task automatic restart_scan();
        offer(noisy_item(CMD_RESTART));
    endtask

    // write every entry the scan can read, only text letters; densities in percent
    task automatic rebuild_automaton(input int hot_pct, input int cold_pct, input int term_pct);
        int pct;
        for (int i = 0; i < USED_NODES; i++) begin
            load_node(used_node(i), acyclic_fail(i), $urandom_range(0, 99) < term_pct,
                      ID_W'($urandom()));
            for (int l = 0; l < LOADED_LETTERS; l++) begin
                pct = (l < HOT_LETTERS) ? hot_pct : cold_pct;
                load_child(used_node(i), loaded_letter(l), $urandom_range(0, 99) < pct,
                           used_node($urandom_range(0, USED_NODES - 1)));
            end
        end
    endtask

    // mixed traffic; writes keep every reachable entry loaded and chains acyclic
    task automatic random_item();
        int r;
        int i;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, USED_NODES - 1);
        if (r < 72) begin
            scan_letter(pick_letter());
        end else if (r < 76) begin
            restart_scan();
        end else if (r < 88) begin
            load_child(($urandom_range(0, 99) < 85) ? used_node(i)
                           : NODE_W'($urandom_range(USED_NODES - 1, NODE_COUNT - 2)),
                       ($urandom_range(0, 99) < 90)
                           ? loaded_letter($urandom_range(0, LOADED_LETTERS - 1))
                           : SYM_W'($urandom_range(ALPHABET_SIZE, 31)),
                       1'($urandom_range(0, 1)),
                       used_node($urandom_range(0, USED_NODES - 1)));
        end else if ($urandom_range(0, 99) < 85) begin
            load_node(used_node(i), acyclic_fail(i), 1'($urandom_range(0, 1)),
                      ID_W'($urandom()));
        end else begin
            load_node(NODE_W'($urandom_range(USED_NODES - 1, NODE_COUNT - 2)),
                      NODE_W'($urandom()), 1'($urandom_range(0, 1)), ID_W'($urandom()));
        end
    endtask

    // stop offering and wait for every owed result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
    endtask

    // result side ready with random stalls and one long hold on request
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_ask && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    stall_left = idle_len();
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty automaton, acyclic fail links
        rebuild_automaton(0, 0, 0);
        drain();

        // small chain a-b-z with terminals along the suffix links
        load_child(NODE_W'(0), LETTER_A, 1'b1, NODE_W'(1));
        load_child(NODE_W'(1), LETTER_B, 1'b1, NODE_W'(2));
        load_child(NODE_W'(2), LETTER_Z, 1'b1, NODE_W'(NODE_COUNT - 1));
        load_node(NODE_W'(1), NODE_W'(0), 1'b1, ID_W'(0));
        load_node(NODE_W'(2), NODE_W'(1), 1'b1, ID_W'(NODE_COUNT - 1));
        load_node(NODE_W'(NODE_COUNT - 1), NODE_W'(2), 1'b1, ID_W'('h155));
        // child write with a letter beyond the alphabet is dropped
        load_child(NODE_W'(5), BEYOND_MID, 1'b1, NODE_W'(3));
        scan_letter(LETTER_A);
        scan_letter(LETTER_B);
        scan_letter(LETTER_Z);
        // fail walk from the deepest node back to the root
        scan_letter(LETTER_A);
        // no child anywhere, and letters out of range
        scan_letter(LETTER_Q);
        scan_letter(BEYOND_HI);
        restart_scan();
        scan_letter(LETTER_B);
        // two-node fail cycle: suffix walk overflows, then the fail walk runs out
        load_node(NODE_W'(1), NODE_W'(2), 1'b1, ID_W'(7));
        scan_letter(LETTER_A);
        scan_letter(LETTER_C);
        load_node(NODE_W'(1), NODE_W'(0), 1'b1, ID_W'(0));
        // cleared child link: walk falls through to the root
        load_child(NODE_W'(2), LETTER_Z, 1'b0, NODE_W'($urandom()));
        scan_letter(LETTER_A);
        scan_letter(LETTER_B);
        scan_letter(LETTER_Z);
        scan_letter(BEYOND_LO);
        drain();

        // random automata and text
        rebuild_automaton(75, 20, 40);
        drain();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                // dense terminals for long report lists
                rebuild_automaton(85, 40, 90);
                drain();
            end
            steady = (ph == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == 10)
                    hold_ask = 1'b1;
                random_item();
            end
            drain();
            steady = 1'b0;
        end

        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mpam_pkg.sv
rtl/mpam_ctrl.sv
rtl/mpam_dp.sv
rtl/multi_pattern_automaton_matcher_unit.sv
dv/mpam_match_checker.sv
dv/multi_pattern_automaton_matcher_unit_tb.sv
